FILE: hdl/pwm_duty_soft_ramp_core_assert.svh
// Assertion macros for the soft-ramp duty controller.
`ifndef PWM_DUTY_SOFT_RAMP_CORE_ASSERT_SVH
`define PWM_DUTY_SOFT_RAMP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define PDSR_ASSERT_IMP(label, ant, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error("pdsr: same-cycle check failed");
// Antecedent implies consequent in the next cycle.
`define PDSR_ASSERT_NXT(label, ant, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error("pdsr: next-cycle check failed");
`else
`define PDSR_ASSERT_IMP(label, ant, cons)
`define PDSR_ASSERT_NXT(label, ant, cons)
`endif
`endif

FILE: hdl/pdsr_pkg.sv
// Shared types and constants for the soft-ramp duty controller.
package pdsr_pkg;

   localparam int DUTY_W  = 14;
   localparam int RAW_W   = 15;
   localparam int RES_W   = 4;
   localparam int PROD_W  = 29;
   localparam int DIV_STEPS = PROD_W;
   localparam int CNT_W   = $clog2(DIV_STEPS);

   // raw duty = product / 10000 = (product >> 4) / 625, by reciprocal multiply;
   // exact for every product below 2^29
   localparam int SCALE_PRE = 4;
   localparam int RECIP_W   = 26;
   localparam int RECIP_SH  = 35;
   localparam int SCALE_W   = PROD_W - SCALE_PRE + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_625 = 26'd54975582;

   localparam logic [DUTY_W-1:0] DUTY_FULL     = 14'd10000;
   localparam logic [DUTY_W-1:0] RAMP_MIN_STEP = 14'd10;
   localparam logic [DUTY_W-1:0] TICK_MAX      = 14'd16383;
   localparam logic [DUTY_W-1:0] MIN_DUTY_RST  = 14'd0;
   localparam logic [DUTY_W-1:0] MAX_DUTY_RST  = 14'd10000;
   localparam logic [DUTY_W-1:0] RAMP_TIME_RST = 14'd0;
   localparam logic [RES_W-1:0]  RES_BITS_RST  = 4'd10;

   typedef enum logic [1:0] {
      CMD_SET  = 2'd0,
      CMD_TICK = 2'd1,
      CMD_STOP = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_MIN_DUTY  = 2'd0,
      REG_MAX_DUTY  = 2'd1,
      REG_RAMP_TIME = 2'd2,
      REG_RES_BITS  = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_MUL_Q,
      ST_DIV_Q,
      ST_FIX_Q,
      ST_MUL_R,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic accept;
      logic apply;
      logic mul_q;
      logic div_step;
      logic fix_q;
      logic mul_r;
      logic load_out;
   } ctl_type;

   typedef struct packed {
      logic ramp_step;
   } status_type;

endpackage

FILE: hdl/pdsr_ctrl.sv
// Sequencer for the soft-ramp duty controller: handshakes and step control.
module pdsr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  pdsr_pkg::status_type status,
   output pdsr_pkg::ctl_type    ctl
);
   import pdsr_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;
   logic             cnt_last;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign cnt_last  = (cnt_ff == CNT_W'(DIV_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_APPLY;
         ST_APPLY: state_in = status.ramp_step ? ST_MUL_Q : ST_MUL_R;
         ST_MUL_Q: state_in = ST_DIV_Q;
         ST_DIV_Q: if (cnt_last) state_in = ST_FIX_Q;
         ST_FIX_Q: state_in = ST_MUL_R;
         ST_MUL_R: state_in = ST_SEND;
         ST_SEND:  if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl        = '0;
      req_tready = 1'b0;
      cnt_in     = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ctl.accept = req_tvalid;
         end
         ST_APPLY: ctl.apply = 1'b1;
         ST_MUL_Q: begin
            ctl.mul_q = 1'b1;
            cnt_in    = '0;
         end
         ST_DIV_Q: begin
            ctl.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
         end
         ST_FIX_Q: ctl.fix_q = 1'b1;
         ST_MUL_R: ctl.mul_r = 1'b1;
         ST_SEND: ctl.load_out = slot_free;
         default: ctl = '0;
      endcase
   end

   always_comb begin
      if (ctl.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/pdsr_datapath.sv
// Duty state, configuration registers, shared multiplier, divider and reciprocal scaling.
module pdsr_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_addr,
   input  logic [13:0]          csr_wdata,
   input  logic [15:0]          req_tdata,
   input  logic [1:0]           req_tuser,
   input  pdsr_pkg::ctl_type    ctl,
   output pdsr_pkg::status_type status,
   output logic [47:0]          rsp_tdata
);
   import pdsr_pkg::*;

   // configuration
   logic [DUTY_W-1:0] min_duty_ff, max_duty_ff, ramp_time_ff;
   logic [RES_W-1:0]  res_bits_ff;

   // duty state
   logic [DUTY_W-1:0] present_ff, present_in;
   logic [DUTY_W-1:0] goal_ff, goal_in;
   logic [DUTY_W-1:0] origin_ff, origin_in;
   logic [DUTY_W-1:0] elapsed_ff, elapsed_in;
   logic              ramping_ff, ramping_in;

   // latched item
   cmd_type           cmd_ff;
   logic [DUTY_W-1:0] req_ff;

   // divider
   logic [PROD_W-1:0] quo_ff;
   logic [DUTY_W-1:0] rem_ff;
   logic [DUTY_W-1:0] dvs_ff;
   logic [DUTY_W:0]   trial;
   logic              trial_ge;
   logic [DUTY_W:0]   trial_sub;

   // scaling to the counter resolution
   logic [SCALE_W-1:0] scale_prod;

   logic [47:0]       out_ff;

   logic [DUTY_W-1:0] clamp_v;
   logic [DUTY_W-1:0] set_diff;
   logic [DUTY_W-1:0] elapsed_step;
   logic              ramp_down;
   logic [DUTY_W-1:0] ramp_mag;
   logic [DUTY_W-1:0] quo_lo;
   logic [15:0]       top_wide;
   logic [RAW_W-1:0]  top_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_duty_ff  <= MIN_DUTY_RST;
         max_duty_ff  <= MAX_DUTY_RST;
         ramp_time_ff <= RAMP_TIME_RST;
         res_bits_ff  <= RES_BITS_RST;
      end else if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_MIN_DUTY:  min_duty_ff  <= csr_wdata;
            REG_MAX_DUTY:  max_duty_ff  <= csr_wdata;
            REG_RAMP_TIME: ramp_time_ff <= csr_wdata;
            REG_RES_BITS:  res_bits_ff  <= csr_wdata[RES_W-1:0];
            default:       res_bits_ff  <= res_bits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff <= cmd_type'(req_tuser);
         req_ff <= req_tdata[DUTY_W-1:0];
      end
   end

   // clamp: max first, then min, then full scale
   always_comb begin
      clamp_v = req_ff;
      if (clamp_v > max_duty_ff) clamp_v = max_duty_ff;
      if (clamp_v < min_duty_ff) clamp_v = min_duty_ff;
      if (clamp_v > DUTY_FULL)   clamp_v = DUTY_FULL;
   end

   assign set_diff     = (clamp_v > present_ff) ? clamp_v - present_ff : present_ff - clamp_v;
   assign elapsed_step = (elapsed_ff < TICK_MAX) ? elapsed_ff + DUTY_W'(1) : elapsed_ff;
   assign ramp_down    = goal_ff < origin_ff;
   assign ramp_mag     = ramp_down ? origin_ff - goal_ff : goal_ff - origin_ff;
   assign quo_lo       = quo_ff[DUTY_W-1:0];
   assign top_wide     = (16'd1 << res_bits_ff) - 16'd1;
   assign top_val      = top_wide[RAW_W-1:0];

   assign status.ramp_step = (cmd_ff == CMD_TICK) && ramping_ff && (elapsed_step < ramp_time_ff);

   always_comb begin
      present_in = present_ff;
      goal_in    = goal_ff;
      origin_in  = origin_ff;
      elapsed_in = elapsed_ff;
      ramping_in = ramping_ff;
      if (ctl.apply) begin
         case (cmd_ff)
            CMD_SET: begin
               goal_in = clamp_v;
               if ((ramp_time_ff != '0) && (set_diff > RAMP_MIN_STEP)) begin
                  origin_in  = present_ff;
                  elapsed_in = '0;
                  ramping_in = 1'b1;
               end else begin
                  present_in = clamp_v;
               end
            end
            CMD_TICK: begin
               if (ramping_ff) begin
                  elapsed_in = elapsed_step;
                  if (elapsed_step >= ramp_time_ff) begin
                     present_in = goal_ff;
                     ramping_in = 1'b0;
                  end
               end
            end
            CMD_STOP: begin
               present_in = '0;
               goal_in    = '0;
               elapsed_in = '0;
               ramping_in = 1'b0;
            end
            default: ramping_in = ramping_ff;
         endcase
      end else if (ctl.fix_q) begin
         present_in = ramp_down ? origin_ff - quo_lo : origin_ff + quo_lo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         goal_ff    <= '0;
         origin_ff  <= '0;
         elapsed_ff <= '0;
         ramping_ff <= 1'b0;
      end else begin
         present_ff <= present_in;
         goal_ff    <= goal_in;
         origin_ff  <= origin_in;
         elapsed_ff <= elapsed_in;
         ramping_ff <= ramping_in;
      end
   end

   // one quotient bit per step
   assign trial     = {rem_ff, quo_ff[PROD_W-1]};
   assign trial_ge  = trial >= {1'b0, dvs_ff};
   assign trial_sub = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (ctl.mul_q) begin
         quo_ff <= PROD_W'(ramp_mag) * PROD_W'(elapsed_ff);
         rem_ff <= '0;
         dvs_ff <= ramp_time_ff;
      end else if (ctl.mul_r) begin
         quo_ff <= PROD_W'(present_ff) * PROD_W'(top_val);
      end else if (ctl.div_step) begin
         quo_ff <= {quo_ff[PROD_W-2:0], trial_ge};
         rem_ff <= trial_ge ? trial_sub[DUTY_W-1:0] : trial[DUTY_W-1:0];
      end
   end

   // divide the scaled duty by full scale: drop the factor 16, multiply by 1/625
   assign scale_prod = SCALE_W'(quo_ff[PROD_W-1:SCALE_PRE]) * SCALE_W'(RECIP_625);

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         out_ff <= {4'd0, ramping_ff, goal_ff, present_ff, scale_prod[RECIP_SH +: RAW_W]};
      end
   end

   assign rsp_tdata = out_ff;

endmodule

FILE: hdl/pwm_duty_soft_ramp_core.sv
// Top level of the soft-ramp duty controller.
//
// Usage: one transaction on req_ carries a command in req_tuser (set duty,
// one-millisecond tick, emergency stop, no-op) and a requested duty in req_tdata.
// Every accepted transaction yields exactly one transaction on rsp_ with the
// PWM compare value, the applied duty, the target duty and the ramp flag.
// Duty values are in hundredths of a percent.
// Set, stop and ticks that end or skip a ramp pass apply, the scaling
// multiply and send; a tick inside a running ramp interpolates in between by
// a multiply, a restoring divider that retires one quotient bit per cycle
// over 29 steps and an update of the applied duty. Scaling to the counter
// resolution multiplies by the top value, then by the full-scale reciprocal.
// One transaction at a time; the next is taken in the cycle after the load.
// The result sits in an output register: a new request is taken while an
// earlier result still waits, and a stalled rsp_tready holds the last
// result and only delays the next one at its final step.
// Reset (synchronous) clears duty, goal, ramp state and loads the register
// defaults: min 0, max 10000, ramp time 0, resolution 10 bits.
// Write csr_ registers only while no transaction is in flight.
`include "pwm_duty_soft_ramp_core_assert.svh"
module pwm_duty_soft_ramp_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [13:0] duty_request, [15:14] zero
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [14:0] raw_duty, [28:15] duty_now,
                                    // [42:29] duty_goal, [43] ramp_active, [47:44] zero
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [13:0] csr_wdata
);
   import pdsr_pkg::*;

   ctl_type    ctl;
   status_type status;

   // sequencer: handshakes, step order, divider step count
   pdsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .ctl        (ctl)
   );

   // state, clamp, interpolation and scaling arithmetic
   pdsr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .ctl       (ctl),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

   // busy right after a transaction is taken
   `PDSR_ASSERT_NXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   // applied duty never leaves full scale
   `PDSR_ASSERT_IMP(a_duty_now_range, rsp_tvalid, rsp_tdata[28:15] <= DUTY_FULL)
   // target duty never leaves full scale
   `PDSR_ASSERT_IMP(a_duty_goal_range, rsp_tvalid, rsp_tdata[42:29] <= DUTY_FULL)

endmodule
